>>> rtl/mcc_pkg.sv
package mcc_pkg;

  localparam int CNT_W = 23;
  localparam int SUM_W = 24;
  localparam int ACC_W = 128;
  localparam int YOP_W = 46;
  localparam int DEN_W = 96;
  localparam int PRD_W = 46;
  localparam int RHS_W = 92;
  localparam int SQ_W  = 30;
  localparam int RT_W  = 15;
  localparam int SCALE_SH = 30;

  localparam logic [RT_W-1:0] RT_TOP = 15'd16384;
  localparam logic signed [15:0] Q_ONE = 16'sd16384;

  typedef enum logic [1:0] {
    ST_CALC    = 2'd0,
    ST_IDENT   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_ZERODEN = 2'd3
  } mcc_status_t;

  typedef enum logic [2:0] {
    OP_S12,
    OP_S3,
    OP_S4,
    OP_POS,
    OP_NEG,
    OP_MAG,
    OP_ODD,
    OP_LHS
  } mcc_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_START,
    S_WAIT,
    S_LOOP,
    S_FINISH
  } mcc_state_t;

  typedef struct packed {
    logic    count;
    logic    init;
    logic    start;
    mcc_op_t op;
    logic    load_out;
  } mcc_cmd_t;

  typedef struct packed {
    logic        mul_done;
    logic        search_done;
    mcc_status_t cls;
    logic        out_free;
  } mcc_stat_t;

endpackage

>>> rtl/mcc_ctrl.sv
module mcc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tlast,
  output logic               s_tready,
  input  mcc_pkg::mcc_stat_t stat,
  output mcc_pkg::mcc_cmd_t  cmd
);

  mcc_pkg::mcc_state_t state, state_next;
  mcc_pkg::mcc_op_t    op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcc_pkg::S_IDLE;
      op    <= mcc_pkg::OP_S12;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next   = state;
    op_next      = op;
    s_tready     = 1'b0;
    cmd.count    = 1'b0;
    cmd.init     = 1'b0;
    cmd.start    = 1'b0;
    cmd.op       = op;
    cmd.load_out = 1'b0;
    case (state)
      mcc_pkg::S_IDLE: begin
        s_tready  = 1'b1;
        cmd.count = s_tvalid;
        if (s_tvalid && s_tlast) state_next = mcc_pkg::S_CHECK;
      end
      mcc_pkg::S_CHECK: begin
        cmd.init = 1'b1;
        op_next  = mcc_pkg::OP_S12;
        if (stat.cls == mcc_pkg::ST_CALC) state_next = mcc_pkg::S_START;
        else state_next = mcc_pkg::S_FINISH;
      end
      mcc_pkg::S_START: begin
        cmd.start  = 1'b1;
        state_next = mcc_pkg::S_WAIT;
      end
      mcc_pkg::S_WAIT: begin
        if (stat.mul_done) begin
          state_next = mcc_pkg::S_START;
          case (op)
            mcc_pkg::OP_S12: op_next = mcc_pkg::OP_S3;
            mcc_pkg::OP_S3:  op_next = mcc_pkg::OP_S4;
            mcc_pkg::OP_S4:  op_next = mcc_pkg::OP_POS;
            mcc_pkg::OP_POS: op_next = mcc_pkg::OP_NEG;
            mcc_pkg::OP_NEG: op_next = mcc_pkg::OP_MAG;
            mcc_pkg::OP_ODD: op_next = mcc_pkg::OP_LHS;
            default: state_next = mcc_pkg::S_LOOP;
          endcase
        end
      end
      mcc_pkg::S_LOOP: begin
        // lo/hi are registered with the compare result and are already updated here
        if (stat.search_done) begin
          state_next = mcc_pkg::S_FINISH;
        end else begin
          op_next    = mcc_pkg::OP_ODD;
          state_next = mcc_pkg::S_START;
        end
      end
      mcc_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = mcc_pkg::S_IDLE;
        end
      end
      default: state_next = mcc_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/mcc_dp.sv
module mcc_dp #(
  parameter int MAX_PIXELS = 4194304
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic [15:0]        s_tdata,
  input  mcc_pkg::mcc_cmd_t  cmd,
  output mcc_pkg::mcc_stat_t stat,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [111:0]       m_tdata,
  output logic [1:0]         m_tuser
);

  localparam int CAP_INT = (MAX_PIXELS < 8388607) ? MAX_PIXELS : 8388607;
  localparam logic [mcc_pkg::CNT_W-1:0] CAP = mcc_pkg::CNT_W'(CAP_INT);

  logic [7:0] threshold;
  logic [mcc_pkg::CNT_W-1:0] tp, tn, fp, fn;
  logic [mcc_pkg::SUM_W-1:0] s1, s2, s3, s4;
  logic tfg, gfg;

  logic [mcc_pkg::ACC_W-1:0] acc, xr, x_sel;
  logic [mcc_pkg::YOP_W-1:0] yr, y_sel;
  logic busy;
  mcc_pkg::mcc_op_t op_r;

  logic [mcc_pkg::DEN_W-1:0] den;
  logic [mcc_pkg::PRD_W-1:0] pos, mag;
  logic [mcc_pkg::RHS_W-1:0] rhs;
  logic [mcc_pkg::SQ_W-1:0]  sq;
  logic neg_r;
  logic [mcc_pkg::RT_W-1:0] lo, hi, mid, odd;
  logic [mcc_pkg::RT_W:0] mid_sum;
  logic done;
  mcc_pkg::mcc_status_t cls;
  logic signed [15:0] value;

  assign tfg = s_tdata[7:0] > threshold;
  assign gfg = s_tdata[15:8] > threshold;

  assign s1 = {1'b0, tp} + {1'b0, fp};
  assign s2 = {1'b0, tp} + {1'b0, fn};
  assign s3 = {1'b0, tn} + {1'b0, fp};
  assign s4 = {1'b0, tn} + {1'b0, fn};

  always_ff @(posedge clk) begin
    if (rst) threshold <= 8'd127;
    else if (cfg_we) threshold <= cfg_data;
  end

  // confusion counters, saturating; clear when the result is taken over
  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      tp <= '0;
      tn <= '0;
      fp <= '0;
      fn <= '0;
    end else if (cmd.count) begin
      if (tfg && gfg) begin
        if (tp < CAP) tp <= tp + 1'b1;
      end else if (!tfg && !gfg) begin
        if (tn < CAP) tn <= tn + 1'b1;
      end else if (tfg) begin
        if (fp < CAP) fp <= fp + 1'b1;
      end else begin
        if (fn < CAP) fn <= fn + 1'b1;
      end
    end
  end

  always_comb begin
    if (fp == '0 && fn == '0) cls = mcc_pkg::ST_IDENT;
    else if (tp == '0 && tn == '0) cls = mcc_pkg::ST_NOMATCH;
    else if (s1 == '0 || s2 == '0 || s3 == '0 || s4 == '0) cls = mcc_pkg::ST_ZERODEN;
    else cls = mcc_pkg::ST_CALC;
  end

  assign mid_sum = {1'b0, lo} + {1'b0, hi} + 1'b1;
  assign mid     = mid_sum[mcc_pkg::RT_W:1];
  assign odd     = {mid[mcc_pkg::RT_W-2:0], 1'b0} - 1'b1;

  always_comb begin
    x_sel = '0;
    y_sel = '0;
    case (cmd.op)
      mcc_pkg::OP_S12: begin
        x_sel = mcc_pkg::ACC_W'(s1);
        y_sel = mcc_pkg::YOP_W'(s2);
      end
      mcc_pkg::OP_S3: begin
        x_sel = mcc_pkg::ACC_W'(den);
        y_sel = mcc_pkg::YOP_W'(s3);
      end
      mcc_pkg::OP_S4: begin
        x_sel = mcc_pkg::ACC_W'(den);
        y_sel = mcc_pkg::YOP_W'(s4);
      end
      mcc_pkg::OP_POS: begin
        x_sel = mcc_pkg::ACC_W'(tp);
        y_sel = mcc_pkg::YOP_W'(tn);
      end
      mcc_pkg::OP_NEG: begin
        x_sel = mcc_pkg::ACC_W'(fp);
        y_sel = mcc_pkg::YOP_W'(fn);
      end
      mcc_pkg::OP_MAG: begin
        x_sel = mcc_pkg::ACC_W'(mag);
        y_sel = mag;
      end
      mcc_pkg::OP_ODD: begin
        x_sel = mcc_pkg::ACC_W'(odd);
        y_sel = mcc_pkg::YOP_W'(odd);
      end
      mcc_pkg::OP_LHS: begin
        x_sel = mcc_pkg::ACC_W'(den);
        y_sel = mcc_pkg::YOP_W'(sq);
      end
      default: begin
        x_sel = '0;
        y_sel = '0;
      end
    endcase
  end

  assign done = busy && (yr == '0);

  // shift-add multiplier, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc  <= '0;
      xr   <= x_sel;
      yr   <= y_sel;
      op_r <= cmd.op;
    end else if (busy && !done) begin
      if (yr[0]) acc <= acc + xr;
      xr <= {xr[mcc_pkg::ACC_W-2:0], 1'b0};
      yr <= {1'b0, yr[mcc_pkg::YOP_W-1:1]};
    end
  end

  // init the search bounds, or write back the finished product
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      lo <= '0;
      hi <= mcc_pkg::RT_TOP;
    end else if (done) begin
      case (op_r)
        mcc_pkg::OP_S12, mcc_pkg::OP_S3, mcc_pkg::OP_S4: den <= acc[mcc_pkg::DEN_W-1:0];
        mcc_pkg::OP_POS: pos <= acc[mcc_pkg::PRD_W-1:0];
        mcc_pkg::OP_NEG: begin
          if (pos >= acc[mcc_pkg::PRD_W-1:0]) begin
            mag   <= pos - acc[mcc_pkg::PRD_W-1:0];
            neg_r <= 1'b0;
          end else begin
            mag   <= acc[mcc_pkg::PRD_W-1:0] - pos;
            neg_r <= 1'b1;
          end
        end
        mcc_pkg::OP_MAG: rhs <= acc[mcc_pkg::RHS_W-1:0];
        mcc_pkg::OP_ODD: sq <= acc[mcc_pkg::SQ_W-1:0];
        mcc_pkg::OP_LHS: begin
          if (acc <= {6'b0, rhs, {mcc_pkg::SCALE_SH{1'b0}}}) lo <= mid;
          else hi <= mid - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cls)
      mcc_pkg::ST_IDENT:   value = mcc_pkg::Q_ONE;
      mcc_pkg::ST_NOMATCH: value = -mcc_pkg::Q_ONE;
      mcc_pkg::ST_ZERODEN: value = '0;
      default: value = neg_r ? -$signed({1'b0, lo}) : $signed({1'b0, lo});
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {4'b0, fn, fp, tn, tp, value};
      m_tuser <= cls;
    end
  end

  assign stat.mul_done    = done;
  assign stat.search_done = (lo == hi);
  assign stat.cls         = cls;
  assign stat.out_free    = !m_tvalid || m_tready;

endmodule

>>> rtl/binary_mask_mcc_scorer_core.sv
// Binary mask scorer: when idle, takes one test/truth pixel pair per cycle (tlast
// marks the final pair), binarizes both against the threshold and counts
// TP/TN/FP/FN. After the last pair the Matthews coefficient is worked out by one
// shared shift-add multiplier (one multiplier bit per cycle) driving a 15-step
// binary search, and s_tready is low meanwhile. Trivial cases (identical masks, no
// matches, zero denominator) skip the multiplier. The result word waits in an
// output register; counting of the next image resumes as soon as the result is
// loaded there.
module binary_mask_mcc_scorer_core #(
  parameter int MAX_PIXELS = 4194304
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_data,   // threshold
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,    // test_pixel[7:0], truth_pixel[15:8]
  input  logic         s_tlast,    // last_pixel
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,    // mcc_value, true_pos, true_neg, false_pos, false_neg
  output logic [1:0]   m_tuser     // status
);

  mcc_pkg::mcc_cmd_t  cmd;
  mcc_pkg::mcc_stat_t stat;

  mcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mcc_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> rtl/mcc_checker.sv
module mcc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tlast,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata,
  input logic [1:0]   m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after last pair");

  a_ident_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == mcc_pkg::ST_IDENT |-> m_tdata[15:0] == mcc_pkg::Q_ONE)
    else $error("identical masks without full score");

  a_zeroden_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == mcc_pkg::ST_ZERODEN |-> m_tdata[15:0] == 16'd0)
    else $error("zero denominator with nonzero score");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind binary_mask_mcc_scorer_core mcc_checker u_mcc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> dv/mcc_score_checker.sv
module mcc_score_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [15:0]  s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  input  logic [1:0]   m_tuser,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [22:0] PIX_CAP = 23'd4194304;

  typedef struct packed {
    logic signed [15:0]   mcc;
    mcc_pkg::mcc_status_t status;
    logic [22:0]          tp;
    logic [22:0]          tn;
    logic [22:0]          fp;
    logic [22:0]          fn;
  } score_t;

  score_t      score_q[$];
  logic [7:0]  thresh;
  logic [22:0] n_tp, n_tn, n_fp, n_fn;

  function automatic logic [22:0] bump(input logic [22:0] c);
    return (c < PIX_CAP) ? c + 23'd1 : PIX_CAP;
  endfunction

  // exact rounded 16384*n/sqrt(D) by binary search on (2r-1)^2*D <= 2^30*n^2
  function automatic score_t score_image(input logic [22:0] tp, tn, fp, fn);
    score_t      r;
    logic [127:0] pos, neg, mag, den, rhs, lhs, odd;
    int unsigned lo, hi, mid;
    r.tp = tp; r.tn = tn; r.fp = fp; r.fn = fn;
    if (fp == 0 && fn == 0) begin
      r.status = mcc_pkg::ST_IDENT; r.mcc = mcc_pkg::Q_ONE;
    end else if (tp == 0 && tn == 0) begin
      r.status = mcc_pkg::ST_NOMATCH; r.mcc = -mcc_pkg::Q_ONE;
    end else begin
      pos = 128'(tp) * 128'(tn);
      neg = 128'(fp) * 128'(fn);
      mag = (pos >= neg) ? pos - neg : neg - pos;
      den = (128'(tp) + fp) * (128'(tp) + fn) * (128'(tn) + fp) * (128'(tn) + fn);
      if (den == 0) begin
        r.status = mcc_pkg::ST_ZERODEN; r.mcc = 16'sd0;
      end else begin
        rhs = (mag * mag) << 30;
        lo = 0; hi = 16384;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          odd = 128'(2 * mid - 1);
          lhs = odd * odd * den;
          if (lhs <= rhs) lo = mid;
          else hi = mid - 1;
        end
        r.status = mcc_pkg::ST_CALC;
        r.mcc = (pos >= neg) ? 16'(lo) : -16'(lo);
      end
    end
    return r;
  endfunction

  assign pending = score_q.size();

  always @(posedge clk) begin
    score_t got, want;
    logic   tfg, gfg;
    if (rst) begin
      thresh = 8'd127;
      n_tp = 0; n_tn = 0; n_fp = 0; n_fn = 0;
      score_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) thresh = cfg_data;
      if (s_tvalid && s_tready) begin
        tfg = s_tdata[7:0] > thresh;
        gfg = s_tdata[15:8] > thresh;
        if (tfg && gfg) n_tp = bump(n_tp);
        else if (!tfg && !gfg) n_tn = bump(n_tn);
        else if (tfg) n_fp = bump(n_fp);
        else n_fn = bump(n_fn);
        if (s_tlast) begin
          score_q.push_back(score_image(n_tp, n_tn, n_fp, n_fn));
          n_tp = 0; n_tn = 0; n_fp = 0; n_fn = 0;
        end
      end
      if (m_tvalid && m_tready) begin
        got.mcc = m_tdata[15:0];
        got.status = mcc_pkg::mcc_status_t'(m_tuser);
        got.tp = m_tdata[38:16];
        got.tn = m_tdata[61:39];
        got.fp = m_tdata[84:62];
        got.fn = m_tdata[107:85];
        if (score_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word: %h/%0d", m_tdata, m_tuser);
        end else begin
          want = score_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: mcc %0d/%0d st %0d/%0d tp %0d/%0d tn %0d/%0d",
                        " fp %0d/%0d fn %0d/%0d"},
                       want.mcc, got.mcc, want.status, got.status, want.tp, got.tp,
                       want.tn, got.tn, want.fp, got.fp, want.fn, got.fn);
          end
        end
      end
    end
  end
endmodule

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_we = 0;
  logic [7:0]   cfg_data = 0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [15:0]  s_tdata = 0;
  logic         s_tlast = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [111:0] m_tdata;
  logic [1:0]   m_tuser;
  int           errors, pending, quiet_cycles;
  logic         calm = 0;
  logic [7:0]   thr;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  binary_mask_mcc_scorer_core dut (.*);
  mcc_score_checker chk (.*);

  // no handshake for too long: give up
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL binary_mask_mcc_scorer_core");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 1)) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  task automatic send_pair(input logic [7:0] t, input logic [7:0] g, input logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {g, t};
    s_tlast <= last;
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
  endtask

  // drain, then write the threshold while the block is idle
  task automatic set_threshold(input logic [7:0] v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_image(input int len);
    logic [7:0] t, g;
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      t = 8'($urandom_range(0, 255));
      case (mode)
        0: g = 8'($urandom_range(0, 255));
        1: g = t;
        2: g = t ^ (($urandom_range(0, 7) == 0) ? 8'hff : 8'h00);
        default: begin
          t = 8'(32'(thr) + $urandom_range(0, 2) - 1);
          g = 8'(32'(thr) + $urandom_range(0, 2) - 1);
        end
      endcase
      send_pair(t, g, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    thr = 8'd127;
    set_threshold(thr);
    send_pair(200, 200, 1);
    send_pair(200, 10, 0);
    send_pair(0, 255, 1);
    send_pair(200, 200, 0);
    send_pair(200, 10, 1);
    send_pair(255, 255, 0);
    send_pair(0, 0, 0);
    send_pair(255, 0, 0);
    send_pair(0, 255, 0);
    send_pair(128, 128, 0);
    send_pair(127, 127, 0);
    send_pair(10, 200, 0);
    send_pair(255, 255, 1);
    thr = 8'd0;
    set_threshold(thr);
    send_pair(0, 0, 0);
    send_pair(1, 0, 0);
    send_pair(0, 1, 0);
    send_pair(1, 1, 1);
    thr = 8'd255;
    set_threshold(thr);
    send_pair(255, 0, 0);
    send_pair(255, 255, 1);

    sent = 0;
    while (sent < 1800) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: thr = 8'd0;
          1: thr = 8'd255;
          default: thr = 8'($urandom_range(0, 255));
        endcase
        set_threshold(thr);
      end
      if (sent > 1500) calm = 1'b1;
      begin
        int len;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
        random_image(len);
        sent += len;
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("PASS binary_mask_mcc_scorer_core");
    else $display("FAIL binary_mask_mcc_scorer_core");
    $finish;
  end
endmodule
